// File: rtl/pidfr_pkg.sv
// shared types, register indexes and saturation helpers of the pid regulator
package pidfr_pkg;

  // sequencer states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ERR,
    ST_MUL_INT,
    ST_INT,
    ST_DIV_WAIT,
    ST_MUL_FILT,
    ST_FILT,
    ST_MUL_P,
    ST_ACC_P,
    ST_ACC_I,
    ST_ACC_D,
    ST_OUT
  } pidfr_state_t;

  // register indexes on the configuration port
  typedef enum logic [2:0] {
    REG_GAIN_P     = 3'd0,
    REG_GAIN_I     = 3'd1,
    REG_GAIN_D     = 3'd2,
    REG_OUT_LIMIT  = 3'd3,
    REG_INT_LIMIT  = 3'd4,
    REG_SEP_LIMIT  = 3'd5,
    REG_ALPHA      = 3'd6,
    REG_RAMP_LIMIT = 3'd7
  } pidfr_reg_t;

  localparam int WIDE_W = 72;

  // saturate a wide signed value to the signed 32-bit range
  function automatic logic signed [31:0] sat32(input logic signed [WIDE_W-1:0] v);
    logic signed [WIDE_W-1:0] hi;
    logic signed [WIDE_W-1:0] lo;
    hi = WIDE_W'(64'sh0000_0000_7FFF_FFFF);
    lo = -WIDE_W'(64'sh0000_0000_8000_0000);
    if (v > hi) return 32'sh7FFF_FFFF;
    if (v < lo) return 32'sh8000_0000;
    return v[31:0];
  endfunction

  // clamp to plus or minus a non-negative limit
  function automatic logic signed [32:0] clampsym(input logic signed [32:0] v,
                                                   input logic [30:0] lim);
    logic signed [32:0] pos;
    pos = $signed({2'b00, lim});
    if (v > pos) return pos;
    if (v < -pos) return -pos;
    return v;
  endfunction

endpackage

// File: rtl/pidfr_div.sv
// restoring divider: delta scaled by one, over a positive time step, toward zero
module pidfr_div #(
  parameter int FRAC_BITS = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic signed [31:0] num,
  input  logic        [31:0] den,
  output logic               busy,
  output logic               done,
  output logic signed [31:0] quo
);
  localparam int N  = 32 + FRAC_BITS;
  localparam int CW = $clog2(N + 1);

  logic [N-1:0]  dvd;
  logic [N-1:0]  q;
  logic [31:0]   rem;
  logic [CW-1:0] cnt;
  logic          neg;
  logic [31:0]   trial;
  logic          fits;
  logic [31:0]   mag;

  assign mag   = num[31] ? 32'(-num) : 32'(num);
  assign trial = {rem[30:0], dvd[N-1]};
  assign fits  = trial >= den;

  // one quotient bit a cycle, most significant first
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
        dvd  <= {mag, FRAC_BITS'(0)};
        rem  <= '0;
        q    <= '0;
        neg  <= num[31];
      end else if (busy) begin
        rem <= fits ? trial - den : trial;
        q   <= {q[N-2:0], fits};
        dvd <= {dvd[N-2:0], 1'b0};
        cnt <= cnt + 1'b1;
        if (cnt == CW'(N - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // signed, saturated quotient
  always_comb begin
    logic signed [N:0] sq;
    sq  = neg ? -$signed({1'b0, q}) : $signed({1'b0, q});
    quo = pidfr_pkg::sat32(pidfr_pkg::WIDE_W'(sq));
  end

endmodule

// File: rtl/pid_controller_filtered_ramped_unit.sv
// top level of the positional pid regulator with filtered derivative and ramp
// One word occupies the block from acceptance until its result is loaded into the
// output register (values in Q16.16 at the default FRAC_BITS). Most of this time
// goes to the bit-serial divider that forms the derivative. A single registered
// 33 by 33 multiplier serves the integral product, the filter and the three
// gain terms in turn. The next word is taken once the result is in the output
// register, which holds it until the sink takes it.
module pid_controller_filtered_ramped_unit #(
  parameter int FRAC_BITS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [95:0] s_tdata,   // setpoint [31:0], measured [63:32], time_step [95:64]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // drive [31:0]
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  localparam int ALPHA_W = (FRAC_BITS - 1 > 17) ? FRAC_BITS - 1 : 17;
  localparam logic [31:0] DEFAULT_STEP = 32'(((1 << FRAC_BITS) + 50) / 100);
  localparam logic [ALPHA_W-1:0] ALPHA_RST = ALPHA_W'(1 << (FRAC_BITS - 2));

  // configuration registers
  logic signed [31:0] gain_p, gain_i, gain_d, separation_limit, ramp_limit;
  logic [30:0]        output_limit, integral_limit;
  logic [ALPHA_W-1:0] filter_alpha;

  // state carried between words
  logic signed [31:0] integral_acc, prev_error, filtered_deriv, prev_drive;

  // per-word working registers
  logic signed [31:0] setpoint, measured, dt, err, delta, raw;
  logic signed [34:0] sum;
  logic signed [32:0] mul_a, mul_b;
  logic signed [65:0] prod;
  logic signed [31:0] qterm;

  pidfr_pkg::pidfr_state_t state, state_next;

  logic               div_start, div_busy, div_done;
  logic signed [31:0] div_quo;
  logic               cfg_wr;
  logic [2:0]         cfg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_idx = paddr[4:2];

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      gain_p           <= '0;
      gain_i           <= '0;
      gain_d           <= '0;
      output_limit     <= '0;
      integral_limit   <= '0;
      separation_limit <= '0;
      filter_alpha     <= ALPHA_RST;
      ramp_limit       <= '0;
    end else if (cfg_wr) begin
      unique case (pidfr_pkg::pidfr_reg_t'(cfg_idx))
        pidfr_pkg::REG_GAIN_P:     gain_p           <= pwdata;
        pidfr_pkg::REG_GAIN_I:     gain_i           <= pwdata;
        pidfr_pkg::REG_GAIN_D:     gain_d           <= pwdata;
        pidfr_pkg::REG_OUT_LIMIT:  output_limit     <= pwdata[30:0];
        pidfr_pkg::REG_INT_LIMIT:  integral_limit   <= pwdata[30:0];
        pidfr_pkg::REG_SEP_LIMIT:  separation_limit <= pwdata;
        pidfr_pkg::REG_ALPHA:      filter_alpha     <= ALPHA_W'(pwdata[16:0]);
        pidfr_pkg::REG_RAMP_LIMIT: ramp_limit       <= pwdata;
        default: ;
      endcase
    end
  end

  // register readback
  always_comb begin
    unique case (pidfr_pkg::pidfr_reg_t'(cfg_idx))
      pidfr_pkg::REG_GAIN_P:     prdata = gain_p;
      pidfr_pkg::REG_GAIN_I:     prdata = gain_i;
      pidfr_pkg::REG_GAIN_D:     prdata = gain_d;
      pidfr_pkg::REG_OUT_LIMIT:  prdata = {1'b0, output_limit};
      pidfr_pkg::REG_INT_LIMIT:  prdata = {1'b0, integral_limit};
      pidfr_pkg::REG_SEP_LIMIT:  prdata = separation_limit;
      pidfr_pkg::REG_ALPHA:      prdata = 32'(filter_alpha);
      pidfr_pkg::REG_RAMP_LIMIT: prdata = ramp_limit;
      default:                   prdata = '0;
    endcase
  end

  // shared multiplier, operands picked by the sequencer
  always_comb begin
    unique case (state)
      pidfr_pkg::ST_MUL_INT: begin
        mul_a = 33'(err);
        mul_b = 33'(dt);
      end
      pidfr_pkg::ST_MUL_FILT: begin
        mul_a = $signed(33'(filter_alpha));
        mul_b = 33'(raw) - 33'(filtered_deriv);
      end
      pidfr_pkg::ST_MUL_P: begin
        mul_a = 33'(gain_p);
        mul_b = 33'(err);
      end
      pidfr_pkg::ST_ACC_P: begin
        mul_a = 33'(gain_i);
        mul_b = 33'(integral_acc);
      end
      default: begin
        mul_a = 33'(gain_d);
        mul_b = 33'(filtered_deriv);
      end
    endcase
  end

  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
  end

  // product scaled back with floor rounding and saturated
  assign qterm = pidfr_pkg::sat32(pidfr_pkg::WIDE_W'(prod >>> FRAC_BITS));

  pidfr_div #(.FRAC_BITS(FRAC_BITS)) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (delta),
    .den   (dt),
    .busy  (div_busy),
    .done  (div_done),
    .quo   (div_quo)
  );

  // sequencer state register
  always_ff @(posedge clk) begin
    if (rst) state <= pidfr_pkg::ST_IDLE;
    else     state <= state_next;
  end

  logic out_free;
  assign out_free = !m_tvalid || m_tready;

  // next state and handshake
  always_comb begin
    state_next = state;
    s_tready   = 1'b0;
    div_start  = 1'b0;
    unique case (state)
      pidfr_pkg::ST_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) state_next = pidfr_pkg::ST_ERR;
      end
      pidfr_pkg::ST_ERR:      state_next = pidfr_pkg::ST_MUL_INT;
      pidfr_pkg::ST_MUL_INT: begin
        div_start  = 1'b1;
        state_next = pidfr_pkg::ST_INT;
      end
      pidfr_pkg::ST_INT:      state_next = pidfr_pkg::ST_DIV_WAIT;
      pidfr_pkg::ST_DIV_WAIT: if (div_done) state_next = pidfr_pkg::ST_MUL_FILT;
      pidfr_pkg::ST_MUL_FILT: state_next = pidfr_pkg::ST_FILT;
      pidfr_pkg::ST_FILT:     state_next = pidfr_pkg::ST_MUL_P;
      pidfr_pkg::ST_MUL_P:    state_next = pidfr_pkg::ST_ACC_P;
      pidfr_pkg::ST_ACC_P:    state_next = pidfr_pkg::ST_ACC_I;
      pidfr_pkg::ST_ACC_I:    state_next = pidfr_pkg::ST_ACC_D;
      pidfr_pkg::ST_ACC_D:    state_next = pidfr_pkg::ST_OUT;
      pidfr_pkg::ST_OUT:      if (out_free) state_next = pidfr_pkg::ST_IDLE;
      default:                state_next = pidfr_pkg::ST_IDLE;
    endcase
  end

  // datapath working values
  logic signed [31:0] err_w, delta_w, int_sat, filt_w, drive_c, drive_w;
  logic signed [32:0] mag, ramp_step;
  logic               integrate;

  always_comb begin
    err_w   = pidfr_pkg::sat32(pidfr_pkg::WIDE_W'(33'(setpoint) - 33'(measured)));
    delta_w = pidfr_pkg::sat32(pidfr_pkg::WIDE_W'(33'(err_w) - 33'(prev_error)));
    mag     = err[31] ? -33'(err) : 33'(err);
    integrate = (separation_limit <= 0) || (mag < 33'(separation_limit));
    int_sat = pidfr_pkg::sat32(pidfr_pkg::WIDE_W'(33'(integral_acc) + 33'(qterm)));
    filt_w  = pidfr_pkg::sat32(pidfr_pkg::WIDE_W'(filtered_deriv) +
                               pidfr_pkg::WIDE_W'(prod >>> FRAC_BITS));
    drive_c = 32'(pidfr_pkg::clampsym(
                33'(pidfr_pkg::sat32(pidfr_pkg::WIDE_W'(sum))), output_limit));
    ramp_step = pidfr_pkg::clampsym(33'(drive_c) - 33'(prev_drive), ramp_limit[30:0]);
    drive_w = (ramp_limit > 0) ? 32'(33'(prev_drive) + ramp_step) : drive_c;
  end

  // datapath and carried state
  always_ff @(posedge clk) begin
    if (rst) begin
      integral_acc   <= '0;
      prev_error     <= '0;
      filtered_deriv <= '0;
      prev_drive     <= '0;
      m_tvalid       <= 1'b0;
    end else begin
      // output word valid: set when a result is loaded, cleared when taken
      if (state == pidfr_pkg::ST_OUT && out_free) m_tvalid <= 1'b1;
      else if (m_tready)                          m_tvalid <= 1'b0;
      unique case (state)
        pidfr_pkg::ST_IDLE: begin
          setpoint <= s_tdata[31:0];
          measured <= s_tdata[63:32];
          dt       <= s_tdata[95:64];
        end
        pidfr_pkg::ST_ERR: begin
          err   <= err_w;
          delta <= delta_w;
          if (dt <= 0) dt <= DEFAULT_STEP;
        end
        pidfr_pkg::ST_INT: begin
          if (integrate)
            integral_acc <= 32'(pidfr_pkg::clampsym(33'(int_sat), integral_limit));
        end
        pidfr_pkg::ST_DIV_WAIT: raw <= div_quo;
        pidfr_pkg::ST_FILT:     filtered_deriv <= filt_w;
        pidfr_pkg::ST_ACC_P:    sum <= 35'(qterm);
        pidfr_pkg::ST_ACC_I:    sum <= sum + 35'(qterm);
        pidfr_pkg::ST_ACC_D:    sum <= sum + 35'(qterm);
        pidfr_pkg::ST_OUT: begin
          if (out_free) begin
            m_tdata    <= drive_w;
            prev_drive <= drive_w;
            prev_error <= err;
          end
        end
        default: ;
      endcase
    end
  end

  // the divider runs only while a word is in flight
  assert property (@(posedge clk) disable iff (rst) s_tready |-> !div_busy)
    else $error("divider busy while idle");

  // a finished word always reaches the output register
  assert property (@(posedge clk) disable iff (rst)
    (state == pidfr_pkg::ST_OUT && out_free) |=> m_tvalid)
    else $error("result lost");

  // without the ramp, drive stays within the output limit
  assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && ramp_limit <= 0) |->
      ($signed(m_tdata) <= $signed({1'b0, output_limit}) &&
       $signed(m_tdata) >= -$signed({1'b0, output_limit})))
    else $error("drive beyond output limit");

endmodule

// File: dv/tb_top.sv
// testbench of the pid regulator: directed table, then random words checked by a predictor
`timescale 1ns / 1ps

module tb_top;

  localparam int FRAC = 16;
  localparam longint S32MAX = 64'sd2147483647;
  localparam longint S32MIN = -64'sd2147483648;
  localparam longint DEF_STEP = ((64'sd1 << FRAC) + 50) / 100;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [95:0] s_tdata = '0;   // setpoint [31:0], measured [63:32], time_step [95:64]
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [31:0] m_tdata;        // drive [31:0]
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [4:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  pid_controller_filtered_ramped_unit #(.FRAC_BITS(FRAC)) DUT (.*);

  always #6 clk = ~clk;

  // predictor copy of registers and state
  longint kp, ki, kd, out_lim, int_lim, sep_lim, alpha, ramp;
  longint integ, last_err, deriv, last_drive;

  logic [31:0] drive_q[$];
  int errors = 0;
  int words_out = 0;
  int sink_gap = 0;      // remaining cycles of a sink idle burst
  bit rx_hold = 1'b0;    // long sink hold-off
  bit no_idle = 1'b0;

  function automatic longint sat(longint v);
    if (v > S32MAX) return S32MAX;
    if (v < S32MIN) return S32MIN;
    return v;
  endfunction

  function automatic longint clip(longint v, longint lim);
    if (v > lim) return lim;
    if (v < -lim) return -lim;
    return v;
  endfunction

  function automatic longint floor_shr(longint v);
    return v >>> FRAC;
  endfunction

  function automatic longint fmul(longint a, longint b);
    return sat(floor_shr(a * b));
  endfunction

  function automatic void regs_reset();
    kp = 0; ki = 0; kd = 0; out_lim = 0; int_lim = 0; sep_lim = 0;
    alpha = 64'sd1 << (FRAC - 2); ramp = 0;
    integ = 0; last_err = 0; deriv = 0; last_drive = 0;
  endfunction

  // next drive for one word, updating the predictor state
  function automatic logic [31:0] pid_drive(logic [95:0] w);
    longint sp, ms, dt, e, m, dlt, rawd, sum, drv;
    sp = longint'($signed(w[31:0]));
    ms = longint'($signed(w[63:32]));
    dt = longint'($signed(w[95:64]));
    if (dt <= 0) dt = DEF_STEP;
    e = sat(sp - ms);
    m = e < 0 ? -e : e;
    if (sep_lim <= 0 || m < sep_lim) integ = clip(sat(integ + fmul(e, dt)), int_lim);
    dlt = sat(e - last_err);
    rawd = sat((dlt * (64'sd1 << FRAC)) / dt);
    deriv = sat(deriv + floor_shr(alpha * (rawd - deriv)));
    sum = fmul(kp, e) + fmul(ki, integ) + fmul(kd, deriv);
    drv = clip(sat(sum), out_lim);
    if (ramp > 0) drv = last_drive + clip(drv - last_drive, ramp);
    last_err = e;
    last_drive = drv;
    return drv[31:0];
  endfunction

  task automatic reg_write(pidfr_pkg::pidfr_reg_t idx, logic [31:0] val);
    @(posedge clk);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= {idx, 2'b00}; pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    case (idx)
      pidfr_pkg::REG_GAIN_P:     kp = longint'($signed(val));
      pidfr_pkg::REG_GAIN_I:     ki = longint'($signed(val));
      pidfr_pkg::REG_GAIN_D:     kd = longint'($signed(val));
      pidfr_pkg::REG_OUT_LIMIT:  out_lim = longint'(val[30:0]);
      pidfr_pkg::REG_INT_LIMIT:  int_lim = longint'(val[30:0]);
      pidfr_pkg::REG_SEP_LIMIT:  sep_lim = longint'($signed(val));
      pidfr_pkg::REG_ALPHA:      alpha = longint'(val[16:0]);
      pidfr_pkg::REG_RAMP_LIMIT: ramp = longint'($signed(val));
      default: ;
    endcase
  endtask

  // source idle burst; valid drops only when a gap is taken
  task automatic idle_gap();
    int n;
    if (!no_idle && $urandom_range(0, 3) == 0) begin
      n = $urandom_range(1, 15);
      s_tvalid <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  // offer one word; use_fixed selects the typed-in drive over the predictor
  task automatic send_word(logic [95:0] w, logic [31:0] fixed, bit use_fixed);
    logic [31:0] p;
    idle_gap();
    s_tvalid <= 1'b1;
    s_tdata <= w;
    do @(posedge clk); while (!s_tready);
    p = pid_drive(w);
    drive_q.push_back(use_fixed ? fixed : p);
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    while (drive_q.size() != 0) @(posedge clk);
    repeat (80) @(posedge clk);
  endtask

  function automatic logic [31:0] rnd_val();
    case ($urandom_range(0, 5))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return $urandom_range(0, 1) ? $urandom_range(0, 255) : -$urandom_range(0, 255);
      3: return {{16{1'b0}}, 16'($urandom)} << $urandom_range(0, 8);
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [31:0] rnd_step();
    case ($urandom_range(0, 7))
      0: return 32'd0;
      1: return $urandom;
      2: return -$urandom_range(1, 100);
      default: return $urandom_range(1, 32'h0002_0000);
    endcase
  endfunction

  // sink side: bursts of backpressure, compare against oldest expectation
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        words_out++;
        if (drive_q.size() == 0) begin
          errors++;
          if (errors <= 10) $display("unexpected drive word %h", m_tdata);
        end else begin
          if (m_tdata !== drive_q[0]) begin
            errors++;
            if (errors <= 10)
              $display("drive mismatch: expected %h actual %h", drive_q[0], m_tdata);
          end
          void'(drive_q.pop_front());
        end
      end
      if (rx_hold) begin
        m_tready <= 1'b0;
      end else if (no_idle) begin
        m_tready <= 1'b1;
      end else if (sink_gap != 0) begin
        sink_gap--;
        m_tready <= 1'b0;
      end else if ($urandom_range(0, 7) == 0) begin
        sink_gap = $urandom_range(0, 14);
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  // directed table
  typedef struct {
    logic [95:0] w;
    logic [31:0] drv;
    bit          fixed;
  } dir_row_t;

  dir_row_t dir_rows[$];

  initial begin
    int phase;
    rst = 1'b1;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    regs_reset();

    // after reset all gains and limits are zero: drive must be zero
    dir_rows.push_back('{{32'h0001_0000, 32'h8000_0000, 32'h7FFF_FFFF}, 32'd0, 1'b1});
    dir_rows.push_back('{{32'd0, 32'h7FFF_FFFF, 32'h8000_0000}, 32'd0, 1'b1});
    foreach (dir_rows[i]) send_word(dir_rows[i].w, dir_rows[i].drv, dir_rows[i].fixed);
    dir_rows.delete();
    drain();

    // wide gains, limits at extremes
    reg_write(pidfr_pkg::REG_GAIN_P, 32'h0001_0000);
    reg_write(pidfr_pkg::REG_GAIN_I, 32'h0000_8000);
    reg_write(pidfr_pkg::REG_GAIN_D, 32'hFFFF_0000);
    reg_write(pidfr_pkg::REG_OUT_LIMIT, 32'h7FFF_FFFF);
    reg_write(pidfr_pkg::REG_INT_LIMIT, 32'h7FFF_FFFF);
    reg_write(pidfr_pkg::REG_SEP_LIMIT, 32'h0000_0000);
    reg_write(pidfr_pkg::REG_ALPHA, 32'h0001_0000);
    reg_write(pidfr_pkg::REG_RAMP_LIMIT, 32'h0000_0000);
    // error saturation, zero and negative step, large step
    dir_rows.push_back('{{32'h0000_0100, 32'h8000_0000, 32'h7FFF_FFFF}, 'x, 1'b0});
    dir_rows.push_back('{{32'd0, 32'h8000_0000, 32'h7FFF_FFFF}, 'x, 1'b0});
    dir_rows.push_back('{{32'd0, 32'h8000_0000, 32'h7FFF_FFFF}, 'x, 1'b0});
    dir_rows.push_back('{{32'd0, 32'h0001_0000, 32'h7FFF_FFFF}, 'x, 1'b0});
    dir_rows.push_back('{{32'd1, 32'h8000_0000, 32'h0000_0000}, 'x, 1'b0});
    dir_rows.push_back('{{32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF}, 'x, 1'b0});
    dir_rows.push_back('{{32'h0001_0000, 32'h0000_0000, 32'h0000_0001}, 'x, 1'b0});
    dir_rows.push_back('{{32'hFFFF_0000, 32'h0000_0000, 32'h8000_0000}, 'x, 1'b0});
    foreach (dir_rows[i]) send_word(dir_rows[i].w, dir_rows[i].drv, dir_rows[i].fixed);
    dir_rows.delete();
    drain();

    // separation limit, zero integral limit, ramp, alpha near two
    reg_write(pidfr_pkg::REG_SEP_LIMIT, 32'h0002_0000);
    reg_write(pidfr_pkg::REG_INT_LIMIT, 32'h0000_0000);
    reg_write(pidfr_pkg::REG_RAMP_LIMIT, 32'h0000_4000);
    reg_write(pidfr_pkg::REG_ALPHA, 32'h0001_FFFF);
    reg_write(pidfr_pkg::REG_GAIN_I, 32'h8000_0000);
    reg_write(pidfr_pkg::REG_GAIN_P, 32'h7FFF_FFFF);
    dir_rows.push_back('{{32'h0001_0000, 32'h0000_0000, 32'h0001_0000}, 'x, 1'b0});
    dir_rows.push_back('{{32'h0002_0000, 32'h0000_0000, 32'h0001_0000}, 'x, 1'b0});
    dir_rows.push_back('{{32'h0003_0000, 32'h0000_0000, 32'h0000_0000}, 'x, 1'b0});
    dir_rows.push_back('{{32'h0000_0000, 32'h0003_0000, 32'h0000_0100}, 'x, 1'b0});
    dir_rows.push_back('{{32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0100}, 'x, 1'b0});
    dir_rows.push_back('{{32'h0000_0000, 32'h0000_0000, 32'h0000_0100}, 'x, 1'b0});
    foreach (dir_rows[i]) send_word(dir_rows[i].w, dir_rows[i].drv, dir_rows[i].fixed);
    dir_rows.delete();
    drain();
    // zero output limit forces drive to zero with ramp off
    reg_write(pidfr_pkg::REG_OUT_LIMIT, 32'h0000_0000);
    reg_write(pidfr_pkg::REG_RAMP_LIMIT, 32'hFFFF_FFFF);
    send_word({32'h0000_1000, 32'h0000_0000, 32'h0001_0000}, 32'd0, 1'b1);
    send_word({32'h0000_0000, 32'h7FFF_0000, 32'h0001_0000}, 32'd0, 1'b1);
    drain();

    // random phases with fresh register settings
    for (phase = 0; phase < 12; phase++) begin
      reg_write(pidfr_pkg::REG_GAIN_P, rnd_val());
      reg_write(pidfr_pkg::REG_GAIN_I, rnd_val());
      reg_write(pidfr_pkg::REG_GAIN_D, rnd_val());
      reg_write(pidfr_pkg::REG_OUT_LIMIT, $urandom_range(0, 7) == 0 ? 32'd0 : rnd_val());
      reg_write(pidfr_pkg::REG_INT_LIMIT, rnd_val());
      reg_write(pidfr_pkg::REG_SEP_LIMIT, $urandom_range(0, 1) ? 32'd0 : rnd_val());
      reg_write(pidfr_pkg::REG_ALPHA,
                $urandom_range(0, 3) == 0 ? 32'h0001_FFFF : $urandom_range(0, 65536));
      reg_write(pidfr_pkg::REG_RAMP_LIMIT, $urandom_range(0, 1) ? rnd_val() : 32'd0);
      if (phase == 10) no_idle = 1'b1;
      repeat (78) send_word({rnd_step(), rnd_val(), rnd_val()}, 'x, 1'b0);
      if (phase == 3) begin
        // long sink hold-off while words keep coming
        fork
          begin
            rx_hold = 1'b1;
            repeat (400) @(posedge clk);
            rx_hold = 1'b0;
          end
          repeat (5) send_word({rnd_step(), rnd_val(), rnd_val()}, 'x, 1'b0);
        join
      end
      drain();
    end

    $display("covered reset, directed extremes and %0d drive words over 12 random settings",
             words_out);
    $display("including saturation, default step, separation, ramp and sink hold-off");
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // watchdog
  initial begin
    #20ms;
    $display("DONE: errors detected");
    $finish;
  end

endmodule
